### hw/rtl/brdd_pkg.sv
// Shared constants and register codes for the binary row dilation block.
package brdd_pkg;

    localparam int ROW_WIDTH_DEF  = 64;
    localparam int MAX_RADIUS_DEF = 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int RADIUS_W = 2;
    localparam int IMG_W_W  = 7;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 2'd1;
    localparam logic [IMG_W_W-1:0]  IMG_W_RST  = 7'd64;

    typedef enum logic {
        CFG_RADIUS = 1'b0,
        CFG_WIDTH  = 1'b1
    } t_cfg_reg;

endpackage

### hw/rtl/brdd_if.sv
// Valid/ready stream interfaces for input rows and dilated result rows.
interface brdd_row_if import brdd_pkg::*; #(
    parameter int ROW_WIDTH = ROW_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [ROW_WIDTH-1:0] row_bits;
    logic                 last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

interface brdd_res_if import brdd_pkg::*; #(
    parameter int ROW_WIDTH = ROW_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [ROW_WIDTH-1:0] out_row_bits;
    logic                 out_last;

    modport source (output valid, output out_row_bits, output out_last, input ready);
    modport sink   (input valid, input out_row_bits, input out_last, output ready);
endinterface

### hw/rtl/brdd_ctx_mem.sv
// Context memory holding the row window and row count, with a registered read.
module brdd_ctx_mem import brdd_pkg::*; #(
    parameter int WORD_W = 259
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic              i_wr_en,
    input  logic [WORD_W-1:0] i_wr_data,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [1];
    logic              r_valid;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[0] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

### hw/rtl/brdd_dilate.sv
// Diamond dilation of one output row from the current row and the window.
module brdd_dilate import brdd_pkg::*; #(
    parameter int ROW_WIDTH  = ROW_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic [2*MAX_RADIUS:0][ROW_WIDTH-1:0] i_rows,
    input  logic [RADIUS_W-1:0]                  i_d,
    input  logic [RADIUS_W-1:0]                  i_r,
    input  logic [ROW_WIDTH-1:0]                 i_mask,
    output logic [ROW_WIDTH-1:0]                 o_row
);

    localparam int WIN_DEPTH = 2 * MAX_RADIUS;

    always_comb begin
        logic [ROW_WIDTH-1:0] acc;
        logic [ROW_WIDTH-1:0] spr;
        int                   gap;
        acc = '0;
        for (int j = 0; j <= WIN_DEPTH; j++) begin
            gap = (j >= int'(i_d)) ? (j - int'(i_d)) : (int'(i_d) - j);
            spr = '0;
            if (gap <= int'(i_r)) begin
                spr = i_rows[j];
                for (int k = 1; k <= MAX_RADIUS; k++) begin
                    if (k <= int'(i_r) - gap) begin
                        spr = spr | (i_rows[j] << k) | (i_rows[j] >> k);
                    end
                end
            end
            acc = acc | spr;
        end
        o_row = acc & i_mask;
    end

endmodule

### hw/rtl/binary_row_dilation_diamond.sv
// Top level of the streamed binary row dilation with a cross or diamond element.
//
// Rows enter on i_row, one image row per transaction, bit c = column c; last_row
// marks the final row of an image. Dilated rows leave on o_res, out_last set on
// the final row. Output lags input by radius rows (radius 1: 3x3 cross, radius 2:
// 5x5 diamond); the last row flushes the pending rows, up to three results, and
// the context returns to empty for the next image.
// Registers on the APB port: radius at 0x0, image width at 0x4. Write them only
// while no transaction is in flight.
// An accepted row is registered in the stage with its context read, and its
// result in the output register that drives o_res.valid; flushed results
// follow one per cycle unless the output is held. Throughput: one row per
// cycle unless the output is held; a last row stays in the stage until its
// final flushed result is issued. The rate is set by the read-modify-write of
// the context memory, with the written word forwarded to the following row.
// Reset: radius 1, width 64, window empty.
// Stall: a held output keeps its result; a row that yields a result leaves the
// stage only when the output register is free or drains in the same cycle, and
// the input waits behind it. A row that yields no result leaves without waiting.
module binary_row_dilation_diamond import brdd_pkg::*; #(
    parameter int ROW_WIDTH  = ROW_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    brdd_row_if.sink          i_row,
    brdd_res_if.source        o_res
);

    localparam int WIN_DEPTH = 2 * MAX_RADIUS;
    localparam int SEEN_W    = $clog2(WIN_DEPTH + 1);

    typedef struct packed {
        logic [SEEN_W-1:0]                   seen;
        logic [WIN_DEPTH-1:0][ROW_WIDTH-1:0] win;
    } t_ctx;

    localparam int CTX_W = $bits(t_ctx);

    logic [RADIUS_W-1:0] r_radius;
    logic [IMG_W_W-1:0]  r_img_w;

    logic                r_b_valid;
    logic [ROW_WIDTH-1:0] r_b_row;
    logic                r_b_last;
    logic                r_b_first;
    logic                r_b_hit;
    logic [RADIUS_W-1:0] r_b_d;
    t_ctx                r_fwd;

    logic                 r_out_valid;
    logic [ROW_WIDTH-1:0] r_out_row;
    logic                 r_out_last;

    logic                 cfg_wr;
    logic [RADIUS_W-1:0]  radius_eff;
    logic [IMG_W_W-1:0]   w_eff;
    logic [ROW_WIDTH-1:0] mask;
    logic                 accept;
    logic [CTX_W-1:0]     mem_rd;
    t_ctx                 ctx;
    t_ctx                 n_ctx;
    logic [WIN_DEPTH:0][ROW_WIDTH-1:0] rows;
    logic                 need_emit;
    logic [RADIUS_W-1:0]  d_init;
    logic [RADIUS_W-1:0]  d_cur;
    logic                 slot_free;
    logic                 b_emit;
    logic                 b_more;
    logic                 b_retire;
    logic [ROW_WIDTH-1:0] dil_row;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_img_w  <= IMG_W_RST;
        end else if (cfg_wr) begin
            unique case (t_cfg_reg'(paddr[2]))
                CFG_RADIUS: r_radius <= pwdata[RADIUS_W-1:0];
                CFG_WIDTH:  r_img_w  <= pwdata[IMG_W_W-1:0];
                default:    r_radius <= r_radius;
            endcase
        end
    end

    always_comb begin
        unique case (t_cfg_reg'(paddr[2]))
            CFG_RADIUS: prdata = APB_DW'(r_radius);
            CFG_WIDTH:  prdata = APB_DW'(r_img_w);
            default:    prdata = '0;
        endcase
    end

    // Effective radius and column mask
    always_comb begin
        radius_eff = r_radius;
        if (radius_eff == '0) begin
            radius_eff = RADIUS_W'(1);
        end
        if (radius_eff > RADIUS_W'(MAX_RADIUS)) begin
            radius_eff = RADIUS_W'(MAX_RADIUS);
        end
        w_eff = r_img_w;
        if (w_eff == '0) begin
            w_eff = IMG_W_W'(1);
        end
        if (w_eff > IMG_W_W'(ROW_WIDTH)) begin
            w_eff = IMG_W_W'(ROW_WIDTH);
        end
        for (int c = 0; c < ROW_WIDTH; c++) begin
            mask[c] = (c < int'(w_eff));
        end
    end

    // Context memory read on accept, write on retire
    assign accept      = i_row.valid && i_row.ready;
    assign i_row.ready = !r_b_valid || b_retire;

    brdd_ctx_mem #(
        .WORD_W (CTX_W)
    ) u_ctx_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_wr_en   (b_retire),
        .i_wr_data (n_ctx),
        .o_rd_data (mem_rd)
    );

    assign ctx = r_b_hit ? r_fwd : t_ctx'(mem_rd);

    always_comb begin
        rows[0] = r_b_row & mask;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            rows[k+1] = ctx.win[k] & mask;
        end
    end

    always_comb begin
        n_ctx = '0;
        if (!r_b_last) begin
            n_ctx.win[0] = rows[0];
            for (int k = 1; k < WIN_DEPTH; k++) begin
                n_ctx.win[k] = ctx.win[k-1];
            end
            n_ctx.seen = (ctx.seen < SEEN_W'(WIN_DEPTH)) ? ctx.seen + SEEN_W'(1) : ctx.seen;
        end
    end

    // Result sequencing
    assign slot_free = !r_out_valid || o_res.ready;
    assign need_emit = r_b_last || (ctx.seen >= SEEN_W'(radius_eff));

    always_comb begin
        d_init = radius_eff;
        if (r_b_last && (ctx.seen < SEEN_W'(radius_eff))) begin
            d_init = RADIUS_W'(ctx.seen);
        end
    end

    assign d_cur    = r_b_first ? d_init : r_b_d;
    assign b_more   = r_b_last && (d_cur != '0);
    assign b_emit   = r_b_valid && need_emit && slot_free;
    assign b_retire = r_b_valid && (!need_emit || (slot_free && !b_more));

    brdd_dilate #(
        .ROW_WIDTH  (ROW_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dilate (
        .i_rows (rows),
        .i_d    (d_cur),
        .i_r    (radius_eff),
        .i_mask (mask),
        .o_row  (dil_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (b_retire) begin
                r_b_valid <= 1'b0;
            end
            if (b_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_row   <= i_row.row_bits;
            r_b_last  <= i_row.last_row;
            r_b_first <= 1'b1;
            r_b_hit   <= b_retire;
        end else if (b_emit && b_more) begin
            r_b_first <= 1'b0;
            r_b_d     <= d_cur - RADIUS_W'(1);
        end
        if (b_retire) begin
            r_fwd <= n_ctx;
        end
        if (b_emit) begin
            r_out_row  <= dil_row;
            r_out_last <= r_b_last && (d_cur == '0);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_row_bits = r_out_row;
    assign o_res.out_last     = r_out_last;

    function automatic logic step_in_range(input logic [RADIUS_W-1:0] d);
        return (d < RADIUS_W'(MAX_RADIUS));
    endfunction

    a_flush_clears_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_retire && r_b_last) |=> (r_fwd == '0))
        else $error("context not cleared after last row");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (ctx.seen <= SEEN_W'(WIN_DEPTH)))
        else $error("row count beyond window depth");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !r_b_first) |-> (step_in_range(r_b_d) && r_b_last))
        else $error("flush step out of range");

endmodule
